// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/fpsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsa_pkg
// shared types, constants and the reciprocal table of the stencil averager
// ----------------------------------------------------------------------------
package fpsa_pkg;

	// sample format, signed q8.8
	localparam int SAMPLE_BITS = 16;

	// configuration port
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_W_BITS    = 11;
	localparam int CFG_H_BITS    = 13;
	localparam logic [CFG_W_BITS-1:0] GRID_WIDTH_RESET  = CFG_W_BITS'(64);
	localparam logic [CFG_H_BITS-1:0] GRID_HEIGHT_RESET = CFG_H_BITS'(64);

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	// stencil arithmetic widths
	localparam int SUM_BITS    = SAMPLE_BITS + 3;
	localparam int CNT_BITS    = 3;
	localparam int ABS_BITS    = SAMPLE_BITS + 2;
	localparam int QUO_BITS    = SAMPLE_BITS + 1;
	localparam int RECIP_SHIFT = ABS_BITS + 2;
	localparam int RECIP_BITS  = RECIP_SHIFT + 1;
	localparam int PROD_BITS   = ABS_BITS + RECIP_BITS;

	// rounded-up reciprocals, exact for every magnitude below 2**ABS_BITS
	localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(1 << RECIP_SHIFT);
	localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'(1 << (RECIP_SHIFT - 1));
	localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'(((1 << RECIP_SHIFT) + 2) / 3);
	localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'(1 << (RECIP_SHIFT - 2));
	localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'(((1 << RECIP_SHIFT) + 4) / 5);

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef struct packed {
		op_t                           op;
		logic signed [SAMPLE_BITS-1:0] cell_value;
	} cell_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] avg_value;
		logic                          frame_last;
	} avg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_FIX
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic mul;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic useful;
		logic result;
		logic out_full;
	} dp_status_t;

	function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
		logic [RECIP_BITS-1:0] r;
		case (cnt)
			CNT_BITS'(2): r = RECIP_2;
			CNT_BITS'(3): r = RECIP_3;
			CNT_BITS'(4): r = RECIP_4;
			CNT_BITS'(5): r = RECIP_5;
			default:      r = RECIP_1;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/five_point_stencil_average.sv =====
// ----------------------------------------------------------------------------
// five_point_stencil_average
// five-point stencil average over a raster stream of signed q8.8 cells
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+------------------------
//  cell     | in  | cell_valid / cell_stall        | fpsa_pkg::cell_t
//  avg      | out | avg_valid / avg_stall          | fpsa_pkg::avg_t
//  config   | in  | psel / penable / pwrite/pready | paddr, pwdata, prdata
//
//  a push that yields a result steps through accept with line store read,
//  sum with line store write-back, reciprocal multiply and result load
//  a first-row push ends after the sum, an item that does nothing is dropped in idle
//  the sequence is set by the read-modify-write of the single-write line stores
//  asynchronous active-low reset; the line stores are not cleared and need
//  no clearing pass, every read that feeds a result hits an entry written before
//  a stalled result waits in the output register while the next item is
//  taken; the sequencer only holds in its last step if that register is full
//
module five_point_stencil_average #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// cell stream
	input  logic                                cell_valid,
	output logic                                cell_stall,
	input  fpsa_pkg::cell_t                     cell_data,
	// average stream
	output logic                                avg_valid,
	input  logic                                avg_stall,
	output fpsa_pkg::avg_t                      avg_data,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fpsa_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [fpsa_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [fpsa_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready
);

	localparam int WCNT_BITS = $clog2(MAX_WIDTH + 1);
	localparam int HCNT_BITS = $clog2(MAX_HEIGHT + 1);

	// effective geometry after clamping, and the restart strobe of a write
	logic [WCNT_BITS-1:0]  eff_w;
	logic [HCNT_BITS-1:0]  eff_h;
	logic                  restart;

	// sequencer to datapath
	fpsa_pkg::ctrl_cmd_t   cmd;
	fpsa_pkg::dp_status_t  status;

	// a register write restarts the grid, line store contents are kept
	fpsa_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.eff_w   (eff_w),
		.eff_h   (eff_h),
		.restart (restart)
	);

	// one transaction at a time moves through accept, sum, multiply, load
	fpsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.avg_stall  (avg_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// results trail the input by one row; drain transactions flush the last row
	fpsa_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_data (cell_data),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.restart   (restart),
		.cmd       (cmd),
		.status    (status),
		.avg_stall (avg_stall),
		.avg_valid (avg_valid),
		.avg_data  (avg_data)
	);

endmodule

// ===== hw/rtl/fpsa_regs.sv =====
// ----------------------------------------------------------------------------
// fpsa_regs
// apb register file for grid geometry, clamps it to the supported range
// ----------------------------------------------------------------------------
module fpsa_regs #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fpsa_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [fpsa_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [fpsa_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output logic [$clog2(MAX_WIDTH + 1)-1:0]    eff_w,
	output logic [$clog2(MAX_HEIGHT + 1)-1:0]   eff_h,
	output logic                                restart
);

	localparam int WCNT_BITS = $clog2(MAX_WIDTH + 1);
	localparam int HCNT_BITS = $clog2(MAX_HEIGHT + 1);
	localparam int WCMP_BITS = (fpsa_pkg::CFG_W_BITS > WCNT_BITS) ?
		fpsa_pkg::CFG_W_BITS : WCNT_BITS;
	localparam int HCMP_BITS = (fpsa_pkg::CFG_H_BITS > HCNT_BITS) ?
		fpsa_pkg::CFG_H_BITS : HCNT_BITS;

	logic [fpsa_pkg::CFG_W_BITS-1:0] grid_width_q;
	logic [fpsa_pkg::CFG_H_BITS-1:0] grid_height_q;
	fpsa_pkg::reg_idx_t              idx;
	logic                            wr;
	logic [WCMP_BITS-1:0]            w_ext;
	logic [HCMP_BITS-1:0]            h_ext;

	assign idx     = fpsa_pkg::reg_idx_t'(paddr[fpsa_pkg::CFG_ADDR_BITS-1]);
	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign restart = wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= fpsa_pkg::GRID_WIDTH_RESET;
			grid_height_q <= fpsa_pkg::GRID_HEIGHT_RESET;
		end else if (wr) begin
			case (idx)
				fpsa_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[fpsa_pkg::CFG_W_BITS-1:0];
				fpsa_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[fpsa_pkg::CFG_H_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			fpsa_pkg::REG_GRID_WIDTH:  prdata = fpsa_pkg::CFG_DATA_BITS'(grid_width_q);
			fpsa_pkg::REG_GRID_HEIGHT: prdata = fpsa_pkg::CFG_DATA_BITS'(grid_height_q);
			default:                   prdata = '0;
		endcase
	end

	// zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		w_ext = WCMP_BITS'(grid_width_q);
		if (w_ext == '0) begin
			eff_w = WCNT_BITS'(1);
		end else if (w_ext > WCMP_BITS'(MAX_WIDTH)) begin
			eff_w = WCNT_BITS'(MAX_WIDTH);
		end else begin
			eff_w = WCNT_BITS'(w_ext);
		end
	end

	always_comb begin
		h_ext = HCMP_BITS'(grid_height_q);
		if (h_ext == '0) begin
			eff_h = HCNT_BITS'(1);
		end else if (h_ext > HCMP_BITS'(MAX_HEIGHT)) begin
			eff_h = HCNT_BITS'(MAX_HEIGHT);
		end else begin
			eff_h = HCNT_BITS'(h_ext);
		end
	end

endmodule

// ===== hw/rtl/fpsa_div.sv =====
// ----------------------------------------------------------------------------
// fpsa_div
// divides a stencil sum by its cell count, truncating toward zero
// ----------------------------------------------------------------------------
module fpsa_div (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [fpsa_pkg::SUM_BITS-1:0]   sum,
	input  logic [fpsa_pkg::CNT_BITS-1:0]          cnt,
	output logic [fpsa_pkg::SAMPLE_BITS-1:0]       quo
);

	logic [fpsa_pkg::SUM_BITS-1:0]  mag_full;
	logic [fpsa_pkg::ABS_BITS-1:0]  mag;
	logic [fpsa_pkg::PROD_BITS-1:0] prod_q;
	logic                           neg_q;
	logic [fpsa_pkg::QUO_BITS-1:0]  q_mag;
	logic [fpsa_pkg::QUO_BITS-1:0]  q_signed;

	// magnitude fits abs_bits since at most five samples are summed
	assign mag_full = sum[fpsa_pkg::SUM_BITS-1] ? (~sum + 1'b1) : sum;
	assign mag      = mag_full[fpsa_pkg::ABS_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= fpsa_pkg::PROD_BITS'(mag) *
				fpsa_pkg::PROD_BITS'(fpsa_pkg::recip(cnt));
			neg_q  <= sum[fpsa_pkg::SUM_BITS-1];
		end
	end

	assign q_mag    = prod_q[fpsa_pkg::RECIP_SHIFT +: fpsa_pkg::QUO_BITS];
	assign q_signed = neg_q ? (~q_mag + 1'b1) : q_mag;
	assign quo      = q_signed[fpsa_pkg::SAMPLE_BITS-1:0];

endmodule

// ===== hw/rtl/fpsa_dp.sv =====
// ----------------------------------------------------------------------------
// fpsa_dp
// line stores, raster counters, stencil sum and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpsa_dp #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fpsa_pkg::cell_t                    cell_data,
	input  logic [$clog2(MAX_WIDTH + 1)-1:0]   eff_w,
	input  logic [$clog2(MAX_HEIGHT + 1)-1:0]  eff_h,
	input  logic                               restart,
	input  fpsa_pkg::ctrl_cmd_t                cmd,
	output fpsa_pkg::dp_status_t               status,
	input  logic                               avg_stall,
	output logic                               avg_valid,
	output fpsa_pkg::avg_t                     avg_data
);

	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int WCNT_BITS = $clog2(MAX_WIDTH + 1);
	localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
	localparam int HCNT_BITS = $clog2(MAX_HEIGHT + 1);

	typedef struct packed {
		logic drain;
		logic has_l;
		logic has_r;
		logic has_t;
		logic has_b;
		logic result;
		logic last;
	} item_flags_t;

	logic [fpsa_pkg::SAMPLE_BITS-1:0] center_mem [MAX_WIDTH];
	logic [fpsa_pkg::SAMPLE_BITS-1:0] above_mem  [MAX_WIDTH];

	logic [COL_BITS-1:0]                 col_q;
	logic [ROW_BITS-1:0]                 row_q;
	logic                                draining_q;
	logic [WCNT_BITS-1:0]                col_inc;
	logic [HCNT_BITS-1:0]                row_inc;
	logic                                row_last;
	logic                                is_drain;
	item_flags_t                         flags_q;
	logic [fpsa_pkg::SAMPLE_BITS-1:0]    x_q;
	logic [fpsa_pkg::SAMPLE_BITS-1:0]    left_q;
	logic [fpsa_pkg::SAMPLE_BITS-1:0]    cen_rd_q;
	logic [fpsa_pkg::SAMPLE_BITS-1:0]    cen1_rd_q;
	logic [fpsa_pkg::SAMPLE_BITS-1:0]    abv_rd_q;
	logic signed [fpsa_pkg::SUM_BITS-1:0] t_mid, t_l, t_r, t_t, t_b;
	logic signed [fpsa_pkg::SUM_BITS-1:0] sum;
	logic [fpsa_pkg::CNT_BITS-1:0]       cnt;
	logic signed [fpsa_pkg::SUM_BITS-1:0] sum_q;
	logic [fpsa_pkg::CNT_BITS-1:0]       cnt_q;
	logic [fpsa_pkg::SAMPLE_BITS-1:0]    quo;
	logic                                out_valid_q;
	fpsa_pkg::avg_t                      avg_q;

	assign col_inc  = WCNT_BITS'(col_q) + WCNT_BITS'(1);
	assign row_inc  = HCNT_BITS'(row_q) + HCNT_BITS'(1);
	assign row_last = (row_inc >= eff_h);
	assign is_drain = (cell_data.op == fpsa_pkg::OP_DRAIN);

	assign status.useful   = is_drain ? draining_q : !draining_q;
	assign status.result   = flags_q.result;
	assign status.out_full = out_valid_q;

	// item capture and line store reads
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q            <= cell_data.cell_value;
			flags_q.drain  <= is_drain;
			flags_q.has_l  <= (col_q != '0);
			flags_q.has_r  <= (col_inc < eff_w);
			flags_q.has_t  <= is_drain ? (eff_h > HCNT_BITS'(1)) : (row_q >= ROW_BITS'(2));
			flags_q.has_b  <= !is_drain;
			flags_q.result <= is_drain || (row_q != '0);
			flags_q.last   <= is_drain && !(col_inc < eff_w);
			cen_rd_q       <= center_mem[col_q];
			cen1_rd_q      <= center_mem[col_inc[COL_BITS-1:0]];
			abv_rd_q       <= above_mem[col_q];
		end
	end

	// a push shifts the old center value up and stores the new cell
	always_ff @(posedge clk) begin
		if (cmd.update && !flags_q.drain) begin
			center_mem[col_q] <= x_q;
			above_mem[col_q]  <= cen_rd_q;
		end
	end

	always_comb begin
		t_mid = fpsa_pkg::SUM_BITS'(signed'(cen_rd_q));
		t_l   = flags_q.has_l ? fpsa_pkg::SUM_BITS'(signed'(left_q))    : '0;
		t_r   = flags_q.has_r ? fpsa_pkg::SUM_BITS'(signed'(cen1_rd_q)) : '0;
		t_t   = flags_q.has_t ? fpsa_pkg::SUM_BITS'(signed'(abv_rd_q))  : '0;
		t_b   = flags_q.has_b ? fpsa_pkg::SUM_BITS'(signed'(x_q))       : '0;
		sum   = t_mid + t_l + t_r + t_t + t_b;
		cnt   = fpsa_pkg::CNT_BITS'(1) + fpsa_pkg::CNT_BITS'(flags_q.has_l) +
			fpsa_pkg::CNT_BITS'(flags_q.has_r) + fpsa_pkg::CNT_BITS'(flags_q.has_t) +
			fpsa_pkg::CNT_BITS'(flags_q.has_b);
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			sum_q  <= sum;
			cnt_q  <= cnt;
			left_q <= cen_rd_q;
		end
	end

	// raster position, shared by pushes and by the final-row drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (restart) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (cmd.update) begin
			if (flags_q.drain) begin
				if (flags_q.last) begin
					col_q      <= '0;
					draining_q <= 1'b0;
				end else begin
					col_q <= col_inc[COL_BITS-1:0];
				end
			end else if (!flags_q.has_r) begin
				col_q <= '0;
				if (row_last) begin
					row_q      <= '0;
					draining_q <= 1'b1;
				end else begin
					row_q <= row_inc[ROW_BITS-1:0];
				end
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
			end
		end
	end

	fpsa_div u_div (
		.clk (clk),
		.en  (cmd.mul),
		.sum (sum_q),
		.cnt (cnt_q),
		.quo (quo)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.load || (out_valid_q && avg_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			avg_q.avg_value  <= signed'(quo);
			avg_q.frame_last <= flags_q.last;
		end
	end

	assign avg_valid = out_valid_q;
	assign avg_data  = avg_q;

	`ASSERT_PROP(a_load_free, clk, arst_n, cmd.load |-> (!out_valid_q || !avg_stall), "result loaded over a waiting transaction")
	`ASSERT_PROP(a_col_range, clk, arst_n, WCNT_BITS'(col_q) < eff_w, "column counter beyond grid width")
	`ASSERT_PROP(a_row_range, clk, arst_n, HCNT_BITS'(row_q) < eff_h, "row counter beyond grid height")
	`ASSERT_NEVER(a_drain_row, clk, arst_n, draining_q && (row_q != '0), "row counter not cleared while draining")

endmodule

// ===== hw/rtl/fpsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpsa_ctrl
// sequencer: accept, read/sum, multiply, result load
// ----------------------------------------------------------------------------
module fpsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cell_valid,
	output logic                 cell_stall,
	input  logic                 avg_stall,
	input  fpsa_pkg::dp_status_t status,
	output fpsa_pkg::ctrl_cmd_t  cmd
);

	fpsa_pkg::state_t state_q;
	fpsa_pkg::state_t state_next;
	logic             out_free;

	assign out_free = !status.out_full || !avg_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			fpsa_pkg::ST_IDLE: begin
				if (cell_valid && status.useful) begin
					state_next = fpsa_pkg::ST_READ;
				end
			end
			fpsa_pkg::ST_READ: begin
				state_next = status.result ? fpsa_pkg::ST_MUL : fpsa_pkg::ST_IDLE;
			end
			fpsa_pkg::ST_MUL: begin
				state_next = fpsa_pkg::ST_FIX;
			end
			fpsa_pkg::ST_FIX: begin
				if (out_free) begin
					state_next = fpsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = fpsa_pkg::ST_IDLE;
			end
		endcase
	end

	// items that do nothing in the current mode are taken and dropped in idle
	always_comb begin
		cmd        = '0;
		cell_stall = 1'b1;
		case (state_q)
			fpsa_pkg::ST_IDLE: begin
				cell_stall = 1'b0;
				cmd.accept = cell_valid && status.useful;
			end
			fpsa_pkg::ST_READ: begin
				cmd.update = 1'b1;
			end
			fpsa_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
			end
			fpsa_pkg::ST_FIX: begin
				cmd.load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
